[sv/wfps_pkg.sv]
`timescale 1ns / 1ps

package wfps_pkg;

  localparam int READING_W = 13;
  localparam int SPEED_W = 12;
  localparam int THRESH_W = 12;
  localparam int CAL_W = 13;
  localparam int CAL_DIFF_W = 14;
  localparam int GAIN_W = 12;
  localparam int DUTY_W = 12;
  localparam int CASE_W = 2;
  localparam int CORR_W = 18;
  localparam int ERR_W = 16;
  localparam int DER_W = 17;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_INDEX_W = 3;

  localparam int KP_TERM_W = ERR_W + GAIN_W + 1;
  localparam int KD_TERM_W = DER_W + GAIN_W + 1;
  localparam int ACC_W = KD_TERM_W + 1;
  localparam int FRAC_W = 8;
  localparam int QUOT_W = ACC_W - FRAC_W;
  localparam int DUTY_CALC_W = CORR_W + 2;

  localparam int PWM_PERIOD = 2500;
  localparam int LEFT_BASE_DUTY = 1080;
  localparam int RIGHT_BASE_DUTY = 780;

  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_CAL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_CAL = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_DIFF = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KP = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_KD = 3'd6;

  localparam logic [THRESH_W-1:0] RIGHT_THRESHOLD_RST = 12'd1700;
  localparam logic [THRESH_W-1:0] LEFT_THRESHOLD_RST = 12'd1300;
  localparam logic signed [CAL_W-1:0] RIGHT_CAL_RST = 13'sd2690;
  localparam logic signed [CAL_W-1:0] LEFT_CAL_RST = 13'sd2200;
  localparam logic signed [CAL_DIFF_W-1:0] CAL_DIFF_RST = 14'sd490;
  localparam logic [GAIN_W-1:0] KP_RST = 12'd205;
  localparam logic [GAIN_W-1:0] KD_RST = 12'd256;

  localparam logic [CASE_W-1:0] CASE_BOTH = 2'd0;
  localparam logic [CASE_W-1:0] CASE_RIGHT_MISSING = 2'd1;
  localparam logic [CASE_W-1:0] CASE_LEFT_MISSING = 2'd2;
  localparam logic [CASE_W-1:0] CASE_HELD = 2'd3;

endpackage

[sv/wall_follow_pd_steering.sv]
`timescale 1ns / 1ps

// channel  | handshake                  | payload
// ---------+----------------------------+----------------------------------------------
// input    | in_valid / in_ready        | right_reading, left_reading, speed_offset
// output   | out_valid / out_ready      | left_duty, right_duty, wall_case, correction
// config   | cfg_write (no wait)        | cfg_index, cfg_data
//
// One request per cycle sustained while out_ready is high; out_valid rises once a request
// passes the input register, then PD math and saturation into the result register.
// The error/derivative state is updated as a request moves into the result register.
// A stalled output holds the result register; the input register still takes one
// more request, then in_ready drops until the output moves.
// rst is synchronous: clears valids, error/derivative state and restores register defaults.

module wall_follow_pd_steering (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [wfps_pkg::READING_W-1:0]  right_reading,
  input  logic signed [wfps_pkg::READING_W-1:0]  left_reading,
  input  logic signed [wfps_pkg::SPEED_W-1:0]    speed_offset,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [wfps_pkg::DUTY_W-1:0]            left_duty,
  output logic [wfps_pkg::DUTY_W-1:0]            right_duty,
  output logic [wfps_pkg::CASE_W-1:0]            wall_case,
  output logic signed [wfps_pkg::CORR_W-1:0]     correction,
  input  logic                                   cfg_write,
  input  logic [wfps_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [wfps_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic [wfps_pkg::THRESH_W-1:0]          right_threshold;
  logic [wfps_pkg::THRESH_W-1:0]          left_threshold;
  logic signed [wfps_pkg::CAL_W-1:0]      right_cal;
  logic signed [wfps_pkg::CAL_W-1:0]      left_cal;
  logic signed [wfps_pkg::CAL_DIFF_W-1:0] cal_diff;
  logic [wfps_pkg::GAIN_W-1:0]            kp;
  logic [wfps_pkg::GAIN_W-1:0]            kd;

  logic                                   in_valid_q;
  logic signed [wfps_pkg::READING_W-1:0]  right_q;
  logic signed [wfps_pkg::READING_W-1:0]  left_q;
  logic signed [wfps_pkg::SPEED_W-1:0]    speed_q;

  logic signed [wfps_pkg::ERR_W-1:0]      prev_error;
  logic signed [wfps_pkg::DER_W-1:0]      prev_der;

  logic                                   advance;
  logic                                   load;
  logic                                   right_above;
  logic                                   left_above;
  logic                                   right_below;
  logic                                   left_below;
  logic [wfps_pkg::CASE_W-1:0]            case_next;
  logic signed [wfps_pkg::ERR_W-1:0]      error_next;
  logic signed [wfps_pkg::DER_W-1:0]      der_next;
  logic signed [wfps_pkg::GAIN_W:0]       kp_s;
  logic signed [wfps_pkg::GAIN_W:0]       kd_s;
  logic signed [wfps_pkg::KP_TERM_W-1:0]  kp_term;
  logic signed [wfps_pkg::KD_TERM_W-1:0]  kd_term;
  logic signed [wfps_pkg::ACC_W-1:0]      acc;
  logic signed [wfps_pkg::QUOT_W-1:0]     quot;
  logic signed [wfps_pkg::CORR_W-1:0]     corr_next;
  logic signed [wfps_pkg::DUTY_CALC_W-1:0] left_raw;
  logic signed [wfps_pkg::DUTY_CALC_W-1:0] right_raw;
  logic [wfps_pkg::DUTY_W-1:0]            left_duty_next;
  logic [wfps_pkg::DUTY_W-1:0]            right_duty_next;

  localparam logic signed [wfps_pkg::QUOT_W-1:0] QUOT_MAX =
    wfps_pkg::QUOT_W'((1 <<< (wfps_pkg::CORR_W - 1)) - 1);
  localparam logic signed [wfps_pkg::QUOT_W-1:0] QUOT_MIN =
    wfps_pkg::QUOT_W'(-(1 <<< (wfps_pkg::CORR_W - 1)));
  localparam logic signed [wfps_pkg::DUTY_CALC_W-1:0] PERIOD_S =
    wfps_pkg::DUTY_CALC_W'(wfps_pkg::PWM_PERIOD);
  localparam logic signed [wfps_pkg::DUTY_CALC_W-1:0] LEFT_BASE_S =
    wfps_pkg::DUTY_CALC_W'(wfps_pkg::LEFT_BASE_DUTY);
  localparam logic signed [wfps_pkg::DUTY_CALC_W-1:0] RIGHT_BASE_S =
    wfps_pkg::DUTY_CALC_W'(wfps_pkg::RIGHT_BASE_DUTY);

  assign advance  = !out_valid || out_ready;
  assign load     = in_valid_q && advance;
  assign in_ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_threshold <= wfps_pkg::RIGHT_THRESHOLD_RST;
      left_threshold  <= wfps_pkg::LEFT_THRESHOLD_RST;
      right_cal       <= wfps_pkg::RIGHT_CAL_RST;
      left_cal        <= wfps_pkg::LEFT_CAL_RST;
      cal_diff        <= wfps_pkg::CAL_DIFF_RST;
      kp              <= wfps_pkg::KP_RST;
      kd              <= wfps_pkg::KD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        wfps_pkg::REG_RIGHT_THRESHOLD: right_threshold <= cfg_data[wfps_pkg::THRESH_W-1:0];
        wfps_pkg::REG_LEFT_THRESHOLD:  left_threshold  <= cfg_data[wfps_pkg::THRESH_W-1:0];
        wfps_pkg::REG_RIGHT_CAL:       right_cal       <= $signed(cfg_data[wfps_pkg::CAL_W-1:0]);
        wfps_pkg::REG_LEFT_CAL:        left_cal        <= $signed(cfg_data[wfps_pkg::CAL_W-1:0]);
        wfps_pkg::REG_CAL_DIFF:        cal_diff        <= $signed(cfg_data);
        wfps_pkg::REG_KP:              kp              <= cfg_data[wfps_pkg::GAIN_W-1:0];
        wfps_pkg::REG_KD:              kd              <= cfg_data[wfps_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      right_q <= right_reading;
      left_q  <= left_reading;
      speed_q <= speed_offset;
    end
  end

  // thresholds are non-negative; compare one bit wider as signed
  assign right_above = right_q > $signed({1'b0, right_threshold});
  assign left_above  = left_q  > $signed({1'b0, left_threshold});
  assign right_below = right_q < $signed({1'b0, right_threshold});
  assign left_below  = left_q  < $signed({1'b0, left_threshold});

  always_comb begin
    error_next = prev_error;
    der_next   = prev_der;
    if (right_above && left_above) begin
      case_next  = wfps_pkg::CASE_BOTH;
      error_next = wfps_pkg::ERR_W'(right_q) - wfps_pkg::ERR_W'(left_q)
                   - wfps_pkg::ERR_W'(cal_diff);
    end else if (right_below) begin
      case_next  = wfps_pkg::CASE_RIGHT_MISSING;
      error_next = wfps_pkg::ERR_W'(left_cal) - wfps_pkg::ERR_W'(left_q);
    end else if (left_below) begin
      case_next  = wfps_pkg::CASE_LEFT_MISSING;
      error_next = wfps_pkg::ERR_W'(right_q) - wfps_pkg::ERR_W'(right_cal);
    end else begin
      case_next  = wfps_pkg::CASE_HELD;
    end
    if (case_next != wfps_pkg::CASE_HELD) begin
      der_next = wfps_pkg::DER_W'(error_next) - wfps_pkg::DER_W'(prev_error);
    end
  end

  assign kp_s    = $signed({1'b0, kp});
  assign kd_s    = $signed({1'b0, kd});
  assign kp_term = wfps_pkg::KP_TERM_W'(kp_s) * wfps_pkg::KP_TERM_W'(error_next);
  assign kd_term = wfps_pkg::KD_TERM_W'(kd_s) * wfps_pkg::KD_TERM_W'(der_next);
  assign acc     = wfps_pkg::ACC_W'(kp_term) + wfps_pkg::ACC_W'(kd_term);

  // Q8 to integer, rounding toward zero
  always_comb begin
    quot = acc[wfps_pkg::ACC_W-1:wfps_pkg::FRAC_W];
    if (acc[wfps_pkg::ACC_W-1] && (acc[wfps_pkg::FRAC_W-1:0] != '0)) begin
      quot = quot + wfps_pkg::QUOT_W'(1);
    end
    if (quot > QUOT_MAX) begin
      corr_next = QUOT_MAX[wfps_pkg::CORR_W-1:0];
    end else if (quot < QUOT_MIN) begin
      corr_next = QUOT_MIN[wfps_pkg::CORR_W-1:0];
    end else begin
      corr_next = quot[wfps_pkg::CORR_W-1:0];
    end
  end

  assign left_raw  = LEFT_BASE_S - wfps_pkg::DUTY_CALC_W'(speed_q)
                     - wfps_pkg::DUTY_CALC_W'(corr_next);
  assign right_raw = RIGHT_BASE_S - wfps_pkg::DUTY_CALC_W'(speed_q)
                     + wfps_pkg::DUTY_CALC_W'(corr_next);

  always_comb begin
    if (left_raw < 0) begin
      left_duty_next = '0;
    end else if (left_raw > PERIOD_S) begin
      left_duty_next = PERIOD_S[wfps_pkg::DUTY_W-1:0];
    end else begin
      left_duty_next = left_raw[wfps_pkg::DUTY_W-1:0];
    end
    if (right_raw < 0) begin
      right_duty_next = '0;
    end else if (right_raw > PERIOD_S) begin
      right_duty_next = PERIOD_S[wfps_pkg::DUTY_W-1:0];
    end else begin
      right_duty_next = right_raw[wfps_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_error <= '0;
      prev_der   <= '0;
    end else begin
      if (advance) begin
        out_valid <= in_valid_q;
      end
      if (load) begin
        prev_error <= error_next;
        prev_der   <= der_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_duty  <= left_duty_next;
      right_duty <= right_duty_next;
      wall_case  <= case_next;
      correction <= corr_next;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_valid_q)
    else $error("pipeline not empty after reset");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_duty <= PERIOD_S[wfps_pkg::DUTY_W-1:0])
                  && (right_duty <= PERIOD_S[wfps_pkg::DUTY_W-1:0]))
    else $error("duty above period");

  a_held_state: assert property (@(posedge clk) disable iff (rst)
    load && (case_next == wfps_pkg::CASE_HELD)
    |=> (prev_error == $past(prev_error)) && (prev_der == $past(prev_der)))
    else $error("held case changed error state");

  a_state_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(prev_error) && $stable(prev_der))
    else $error("error state changed without a request");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule
